@@ sv/subsrch_pkg.sv @@
// Shared constants, types and register codes for the substring search block.
package subsrch_pkg;

  localparam int MAX_PATTERN_LEN = 16;
  localparam int POSITION_BITS   = 16;
  localparam int STORED_BYTES    = 16;
  localparam int LEN_MAX         = (MAX_PATTERN_LEN < STORED_BYTES) ?
                                   MAX_PATTERN_LEN : STORED_BYTES;
  localparam int LEN_W           = 5;
  localparam int COUNT_W         = POSITION_BITS + 1;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int BYTE_W          = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic step;
    logic clear;
  } step_ctrl_t;

  typedef struct packed {
    logic                     found;
    logic [POSITION_BITS-1:0] pos;
    logic                     too_long;
  } result_t;

endpackage

@@ sv/subsrch_cell.sv @@
// One prefix-match cell: holds one bit of the prefix vector.
module subsrch_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  subsrch_pkg::step_ctrl_t       ctrl,
  input  logic                          prev_bit,
  input  logic                          enable,
  input  logic                          is_tail,
  input  logic [subsrch_pkg::BYTE_W-1:0] text_byte,
  input  logic [subsrch_pkg::BYTE_W-1:0] pat_byte,
  output logic                          match_bit,
  output logic                          hit
);

  logic match_next;

  always_comb begin
    match_next = enable && prev_bit && (text_byte == pat_byte);
    hit        = match_next && is_tail;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_bit <= 1'b0;
    end else if (ctrl.step) begin
      match_bit <= ctrl.clear ? 1'b0 : match_next;
    end
  end

endmodule

@@ sv/subsrch_track.sv @@
// Byte counter and first-match tracker; forms the result for the current byte.
module subsrch_track (
  input  logic                          clk,
  input  logic                          rst,
  input  subsrch_pkg::step_ctrl_t       ctrl,
  input  logic                          hit,
  input  logic [subsrch_pkg::LEN_W-1:0] len_eff,
  output subsrch_pkg::result_t          res
);

  logic [subsrch_pkg::COUNT_W-1:0]       byte_count;
  logic [subsrch_pkg::COUNT_W-1:0]       byte_count_next;
  logic                                  match_seen;
  logic                                  match_seen_next;
  logic [subsrch_pkg::POSITION_BITS-1:0] first_start;
  logic [subsrch_pkg::POSITION_BITS-1:0] first_start_next;
  logic                                  overflow_seen;
  logic                                  overflow_seen_next;
  logic [subsrch_pkg::LEN_W-1:0]         tail_off;
  logic [subsrch_pkg::COUNT_W-1:0]       tail_ext;
  logic [subsrch_pkg::COUNT_W-1:0]       start;
  logic                                  match_now;

  always_comb begin
    tail_off  = len_eff - subsrch_pkg::LEN_W'(1);
    tail_ext  = subsrch_pkg::COUNT_W'(tail_off);
    start     = byte_count - tail_ext;
    match_now = hit && !match_seen && (byte_count >= tail_ext)
                && !start[subsrch_pkg::COUNT_W-1];
    match_seen_next    = match_seen | match_now;
    first_start_next   = match_now ? start[subsrch_pkg::POSITION_BITS-1:0] : first_start;
    overflow_seen_next = overflow_seen
                         | (!match_seen_next && byte_count[subsrch_pkg::COUNT_W-1]);
    byte_count_next    = (byte_count == '1) ? byte_count
                         : byte_count + subsrch_pkg::COUNT_W'(1);
    res.found    = match_seen_next;
    res.pos      = match_seen_next ? first_start_next : '0;
    res.too_long = overflow_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      match_seen    <= 1'b0;
      first_start   <= '0;
      overflow_seen <= 1'b0;
    end else if (ctrl.step) begin
      if (ctrl.clear) begin
        byte_count    <= '0;
        match_seen    <= 1'b0;
        first_start   <= '0;
        overflow_seen <= 1'b0;
      end else begin
        byte_count    <= byte_count_next;
        match_seen    <= match_seen_next;
        first_start   <= first_start_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

endmodule

@@ sv/substring_search.sv @@
// Top level of the streaming substring search.
//
// Usage:
//   cfg channel: write pattern bytes 0..7 (index 0), bytes 8..15 (index 1) and
//   the pattern length (index 2) while no text is in flight; cfg_ready is
//   always high. A length of zero never matches; lengths above 16 act as 16.
//   in channel: one text byte per word, last_byte marks the end of the text.
//   One byte is taken per cycle while in_ready is high; the prefix cells and
//   the counter update per accepted byte, so the rate is one byte per clock.
//   out channel: one word per text (found, match_position, too_long), valid
//   in the cycle after the last byte is accepted unless the output is stalled.
//   A result register plus one skid entry sit between the sides: the input
//   keeps flowing while a result waits, and in_ready drops only when both
//   entries hold results that the receiver has not taken.
//   Reset clears the pattern registers, the per-text state and both result
//   entries. After each last byte the per-text state starts over.
module substring_search (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [subsrch_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [subsrch_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [subsrch_pkg::BYTE_W-1:0]        text_byte,
  input  logic                                  last_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  found,
  output logic [subsrch_pkg::POSITION_BITS-1:0] match_position,
  output logic                                  too_long
);

  localparam int N = subsrch_pkg::MAX_PATTERN_LEN;

  logic [subsrch_pkg::CFG_W-1:0]  pat_low;
  logic [subsrch_pkg::CFG_W-1:0]  pat_high;
  logic [subsrch_pkg::LEN_W-1:0]  pat_len;
  logic [subsrch_pkg::LEN_W-1:0]  len_eff;
  logic [2*subsrch_pkg::CFG_W-1:0] pat_all;
  logic [N-1:0]                   prefix_bits;
  logic [N-1:0]                   cell_hit;
  logic                           hit;
  subsrch_pkg::step_ctrl_t        ctrl;
  subsrch_pkg::result_t           res_now;
  subsrch_pkg::result_t           out_res;
  subsrch_pkg::result_t           skid_res;
  logic                           skid_valid;
  logic                           push;
  logic                           out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low  <= '0;
      pat_high <= '0;
      pat_len  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        subsrch_pkg::REG_PAT_LOW:  pat_low  <= cfg_data;
        subsrch_pkg::REG_PAT_HIGH: pat_high <= cfg_data;
        subsrch_pkg::REG_PAT_LEN:  pat_len  <= cfg_data[subsrch_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = (pat_len > subsrch_pkg::LEN_W'(subsrch_pkg::LEN_MAX)) ?
              subsrch_pkg::LEN_W'(subsrch_pkg::LEN_MAX) : pat_len;
    pat_all    = {pat_high, pat_low};
    ctrl.step  = in_valid && in_ready;
    ctrl.clear = last_byte;
    hit        = |cell_hit;
    push       = ctrl.step && last_byte;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic                           prev;
    logic                           en;
    logic                           tail;
    logic [subsrch_pkg::BYTE_W-1:0] pbyte;

    if (k == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = prefix_bits[k-1];
    end

    if (k < subsrch_pkg::LEN_MAX) begin : g_used
      assign en    = (len_eff > subsrch_pkg::LEN_W'(k));
      assign tail  = (len_eff == subsrch_pkg::LEN_W'(k + 1));
      assign pbyte = pat_all[subsrch_pkg::BYTE_W*k +: subsrch_pkg::BYTE_W];
    end else begin : g_unused
      assign en    = 1'b0;
      assign tail  = 1'b0;
      assign pbyte = '0;
    end

    subsrch_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .prev_bit  (prev),
      .enable    (en),
      .is_tail   (tail),
      .text_byte (text_byte),
      .pat_byte  (pbyte),
      .match_bit (prefix_bits[k]),
      .hit       (cell_hit[k])
    );
  end

  subsrch_track u_track (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .hit     (hit),
    .len_eff (len_eff),
    .res     (res_now)
  );

  assign in_ready = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res_now;
    end else if (push) begin
      skid_res <= res_now;
    end
  end

  assign found          = out_res.found;
  assign match_position = out_res.pos;
  assign too_long       = out_res.too_long;

endmodule

@@ sv/subsrch_chk.sv @@
// Port-level checker for the substring search block, bound to the top level.
module subsrch_chk (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  found,
  input logic [subsrch_pkg::POSITION_BITS-1:0] match_position,
  input logic                                  too_long
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found)
      && $stable(match_position) && $stable(too_long))
    else $error("result changed while stalled");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_position == '0)
    else $error("position nonzero without a match");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty result register");

endmodule

bind substring_search subsrch_chk u_subsrch_chk (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .found          (found),
  .match_position (match_position),
  .too_long       (too_long)
);
